>>> rtl/ssp_pkg.sv
// Package with command codes, status codes and control types of the sorted set pair engine.
`default_nettype none
package ssp_pkg;

    // Command codes.
    localparam logic [3:0] OP_INSERT    = 4'd0;
    localparam logic [3:0] OP_CLEAR     = 4'd1;
    localparam logic [3:0] OP_INC       = 4'd2;
    localparam logic [3:0] OP_DEC       = 4'd3;
    localparam logic [3:0] OP_EQUAL     = 4'd4;
    localparam logic [3:0] OP_SUBSET    = 4'd5;
    localparam logic [3:0] OP_UNION     = 4'd6;
    localparam logic [3:0] OP_INTERSECT = 4'd7;
    localparam logic [3:0] OP_DIFF      = 4'd8;
    localparam logic [3:0] OP_SYMDIFF   = 4'd9;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    // Cell commands broadcast along the chain.
    localparam logic [2:0] CC_NONE   = 3'd0;
    localparam logic [2:0] CC_INSERT = 3'd1;
    localparam logic [2:0] CC_INC    = 3'd2;
    localparam logic [2:0] CC_DEC    = 3'd3;
    localparam logic [2:0] CC_SHIFT  = 3'd4;

    // Control group from the sequencer to one chain of cells.
    typedef struct packed {
        logic [2:0] cmd;
        logic       rotate;
    } t_chain_ctl;

endpackage
`default_nettype wire

>>> rtl/ssp_cell.sv
// One storage cell of a set chain: holds one key and hands it to its neighbor.
`default_nettype none
module ssp_cell #(
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire                     i_clk,
    input  wire ssp_pkg::t_chain_ctl i_ctl,
    input  wire                     i_occupied,
    input  wire [ELEMENT_WIDTH-1:0] i_key,
    input  wire [ELEMENT_WIDTH-1:0] i_prev_key,
    input  wire                     i_prev_greater,
    input  wire [ELEMENT_WIDTH-1:0] i_next_key,
    output wire [ELEMENT_WIDTH-1:0] o_key,
    output wire                     o_greater
);
    logic [ELEMENT_WIDTH-1:0] r_key;
    logic [ELEMENT_WIDTH-1:0] n_key;

    // Cell key is greater than the key being inserted (or the cell is empty).
    assign o_greater = !i_occupied || (r_key > i_key);
    assign o_key     = r_key;

    // Insert: cells above the spot take the left neighbor, the spot takes the new key.
    always_comb begin
        n_key = r_key;
        if (i_ctl.rotate) begin
            n_key = i_next_key;
        end else begin
            unique case (i_ctl.cmd)
                ssp_pkg::CC_INSERT: begin
                    if (i_prev_greater) begin
                        n_key = i_prev_key;
                    end else if (o_greater) begin
                        n_key = i_key;
                    end
                end
                ssp_pkg::CC_INC: n_key = r_key + 1'b1;
                ssp_pkg::CC_DEC: n_key = r_key - 1'b1;
                default:         n_key = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end
endmodule
`default_nettype wire

>>> rtl/ssp_chain.sv
// A chain of cells holding one sorted set; rotation streams keys out of cell zero.
`default_nettype none
module ssp_chain #(
    parameter int SET_DEPTH     = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire ssp_pkg::t_chain_ctl    i_ctl,
    input  wire [$clog2(SET_DEPTH+1)-1:0] i_count,
    input  wire [ELEMENT_WIDTH-1:0]     i_key,
    output wire [ELEMENT_WIDTH-1:0]     o_head,
    output wire [ELEMENT_WIDTH-1:0]     o_first,
    output wire [ELEMENT_WIDTH-1:0]     o_last,
    output wire                         o_dup
);
    localparam int CW = $clog2(SET_DEPTH+1);
    wire [ELEMENT_WIDTH-1:0] w_key [SET_DEPTH];
    wire                     w_gt  [SET_DEPTH];
    logic [SET_DEPTH-1:0]    w_eq;

    // Rotation moves every key one place toward cell zero; cell zero wraps to the top.
    for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
        localparam int PV = (g == 0) ? 0 : g - 1;
        localparam int NX = (g == SET_DEPTH - 1) ? 0 : g + 1;
        ssp_cell #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_occupied    (CW'(g) < i_count),
            .i_key         (i_key),
            .i_prev_key    (w_key[PV]),
            .i_prev_greater((g == 0) ? 1'b0 : w_gt[PV]),
            .i_next_key    (w_key[NX]),
            .o_key         (w_key[g]),
            .o_greater     (w_gt[g])
        );
        assign w_eq[g] = (CW'(g) < i_count) && (w_key[g] == i_key);
    end

    // Top element sits at count minus one, which is safe to read only when the set is nonempty.
    logic [CW-1:0] w_top;
    assign w_top   = i_count - 1'b1;
    assign o_head  = w_key[0];
    assign o_first = w_key[0];
    assign o_last  = w_key[w_top[$clog2(SET_DEPTH)-1:0]];
    assign o_dup   = |w_eq;
endmodule
`default_nettype wire

>>> rtl/sorted_set_pair_engine.sv
// Top level of the sorted set pair engine: two cell chains and a merge sequencer.
//
// Each command takes one transfer in and gives its result transfers out. Insert, clear,
// increment and decrement finish their work as the command is accepted, and the next command
// is taken once the result transfer is free. Equal, subset and the four set operations
// rotate both chains through their heads, one step a cycle while no result stalls, for at
// most count A plus count B steps, then end the walk, rotate each chain back to order and
// give the final transfer; a result waiting in the output register stalls the walk. Keys
// are held with the sign bit flipped so unsigned order is signed order. No clearing pass
// follows reset.
`default_nettype none
module sorted_set_pair_engine #(
    parameter int SET_DEPTH     = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output wire         s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // op[3:0], which_set[4], value[36:5], zero pad
    output wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    output wire [39:0]  m_axis_tdata,   // status[1:0], answer[2], element[34:3], element_valid[35]
    output wire         m_axis_tlast
);
    localparam int CW = $clog2(SET_DEPTH+1);
    localparam int EW = ELEMENT_WIDTH;
    localparam logic [EW-1:0] SIGN = {1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] KMAX = {EW{1'b1}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [3:0]    r_op;
    logic          r_sel;
    logic [CW-1:0] r_cnt_a, r_cnt_b, n_cnt_a, n_cnt_b;
    logic [CW-1:0] r_i, r_j, n_i, n_j;
    logic          r_any, n_any;
    logic          r_ans, n_ans;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ostat, n_ostat;
    logic          r_oans, n_oans;
    logic [EW-1:0] r_okey, n_okey;
    logic          r_oev, n_oev;
    logic          r_olast, n_olast;
    logic          r_pend, n_pend;
    logic [EW-1:0] r_pkey, n_pkey;

    ssp_pkg::t_chain_ctl w_ctl_a, w_ctl_b;
    wire [EW-1:0] w_head_a, w_head_b, w_first_a, w_first_b, w_last_a, w_last_b;
    wire          w_dup_a, w_dup_b;

    wire [3:0]    w_in_op  = s_axis_tdata[3:0];
    wire          w_in_sel = s_axis_tdata[4];
    wire [EW-1:0] w_in_key = s_axis_tdata[5 +: EW] ^ SIGN;
    wire          w_acc    = s_axis_tvalid && s_axis_tready;
    wire          w_out_free = !r_ovalid || m_axis_tready;

    ssp_chain #(.SET_DEPTH(SET_DEPTH), .ELEMENT_WIDTH(EW)) u_chain_a (
        .i_clk(i_clk), .i_ctl(w_ctl_a), .i_count(r_cnt_a), .i_key(w_in_key),
        .o_head(w_head_a), .o_first(w_first_a), .o_last(w_last_a), .o_dup(w_dup_a)
    );
    ssp_chain #(.SET_DEPTH(SET_DEPTH), .ELEMENT_WIDTH(EW)) u_chain_b (
        .i_clk(i_clk), .i_ctl(w_ctl_b), .i_count(r_cnt_b), .i_key(w_in_key),
        .o_head(w_head_b), .o_first(w_first_b), .o_last(w_last_b), .o_dup(w_dup_b)
    );

    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;

    // Merge walk: the heads of both chains are the next unvisited keys.
    wire w_a_left = r_i < r_cnt_a;
    wire w_b_left = r_j < r_cnt_b;
    wire w_take_a = w_a_left && (!w_b_left || w_head_a < w_head_b);
    wire w_take_b = !w_take_a && w_b_left && (!w_a_left || w_head_b < w_head_a);
    wire w_both   = w_a_left && w_b_left && !w_take_a && !w_take_b;
    wire w_walk_end = (r_i == r_cnt_a) && (r_j == r_cnt_b);

    logic w_emit;
    always_comb begin
        unique case (r_op)
            ssp_pkg::OP_UNION:     w_emit = 1'b1;
            ssp_pkg::OP_INTERSECT: w_emit = w_both;
            ssp_pkg::OP_DIFF:      w_emit = w_take_a;
            default:               w_emit = w_take_a || w_take_b;
        endcase
    end
    wire [EW-1:0] w_cur = w_take_b ? w_head_b : w_head_a;
    wire w_stream = (r_op == ssp_pkg::OP_UNION) || (r_op == ssp_pkg::OP_INTERSECT) ||
                    (r_op == ssp_pkg::OP_DIFF) || (r_op == ssp_pkg::OP_SYMDIFF);

    // Sequencer: commands enter in IDLE; comparisons and streams walk in WALK.
    always_comb begin
        n_state = r_state; n_cnt_a = r_cnt_a; n_cnt_b = r_cnt_b;
        n_i = r_i; n_j = r_j; n_any = r_any; n_ans = r_ans;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_ostat = r_ostat; n_oans = r_oans; n_okey = r_okey; n_oev = r_oev;
        n_olast = r_olast; n_pend = r_pend; n_pkey = r_pkey;
        w_ctl_a = '{cmd: ssp_pkg::CC_NONE, rotate: 1'b0};
        w_ctl_b = '{cmd: ssp_pkg::CC_NONE, rotate: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_ovalid = 1'b1; n_ostat = ssp_pkg::ST_OK; n_oans = 1'b0;
                    n_okey = '0; n_oev = 1'b0; n_olast = 1'b1;
                    n_i = '0; n_j = '0; n_any = 1'b0; n_ans = 1'b1; n_pend = 1'b0;
                    unique case (w_in_op)
                        ssp_pkg::OP_INSERT: begin
                            if (w_in_sel ? w_dup_b : w_dup_a) begin
                                n_ostat = ssp_pkg::ST_DUP;
                            end else if ((w_in_sel ? r_cnt_b : r_cnt_a) == CW'(SET_DEPTH)) begin
                                n_ostat = ssp_pkg::ST_FULL;
                            end else if (w_in_sel) begin
                                w_ctl_b.cmd = ssp_pkg::CC_INSERT; n_cnt_b = r_cnt_b + 1'b1;
                            end else begin
                                w_ctl_a.cmd = ssp_pkg::CC_INSERT; n_cnt_a = r_cnt_a + 1'b1;
                            end
                        end
                        ssp_pkg::OP_CLEAR: begin
                            if (w_in_sel) n_cnt_b = '0;
                            else          n_cnt_a = '0;
                        end
                        ssp_pkg::OP_INC, ssp_pkg::OP_DEC: begin
                            if (w_in_sel ? (r_cnt_b == '0) : (r_cnt_a == '0)) begin
                                n_ostat = ssp_pkg::ST_OK;
                            end else if ((w_in_op == ssp_pkg::OP_INC) ?
                                         ((w_in_sel ? w_last_b : w_last_a) == KMAX) :
                                         ((w_in_sel ? w_first_b : w_first_a) == '0)) begin
                                n_ostat = ssp_pkg::ST_OVF;
                            end else if (w_in_sel) begin
                                w_ctl_b.cmd = (w_in_op == ssp_pkg::OP_INC) ?
                                              ssp_pkg::CC_INC : ssp_pkg::CC_DEC;
                            end else begin
                                w_ctl_a.cmd = (w_in_op == ssp_pkg::OP_INC) ?
                                              ssp_pkg::CC_INC : ssp_pkg::CC_DEC;
                            end
                        end
                        ssp_pkg::OP_EQUAL, ssp_pkg::OP_SUBSET, ssp_pkg::OP_UNION,
                        ssp_pkg::OP_INTERSECT, ssp_pkg::OP_DIFF, ssp_pkg::OP_SYMDIFF: begin
                            n_ovalid = 1'b0; n_state = S_WALK;
                        end
                        default: n_ostat = ssp_pkg::ST_OK;
                    endcase
                end
            end
            S_WALK: begin
                if (w_walk_end) begin
                    n_state = S_FIX;
                end else if (!w_stream || !r_pend || w_out_free || !w_emit) begin
                    // Step one element; a streamed element goes to a holding slot first.
                    w_ctl_a.rotate = w_take_a || w_both;
                    w_ctl_b.rotate = w_take_b || w_both;
                    if (w_take_a || w_both) n_i = r_i + 1'b1;
                    if (w_take_b || w_both) n_j = r_j + 1'b1;
                    if (r_op == ssp_pkg::OP_EQUAL) begin
                        if (!w_both) n_ans = 1'b0;
                    end else if (r_op == ssp_pkg::OP_SUBSET) begin
                        if (r_sel ? w_take_b : w_take_a) n_ans = 1'b0;
                    end else if (w_emit) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1; n_ostat = ssp_pkg::ST_OK; n_oans = 1'b0;
                            n_okey = r_pkey; n_oev = 1'b1; n_olast = 1'b0;
                        end
                        n_pend = 1'b1; n_pkey = w_cur; n_any = 1'b1;
                    end
                end
            end
            S_FIX: begin
                // Rotate the remaining cells so each chain is back in order.
                if (r_i < CW'(SET_DEPTH)) begin
                    w_ctl_a.rotate = 1'b1; n_i = r_i + 1'b1;
                end
                if (r_j < CW'(SET_DEPTH)) begin
                    w_ctl_b.rotate = 1'b1; n_j = r_j + 1'b1;
                end
                if ((r_i == CW'(SET_DEPTH)) && (r_j == CW'(SET_DEPTH))) n_state = S_DONE;
            end
            default: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1; n_ostat = ssp_pkg::ST_OK; n_olast = 1'b1;
                    n_oans = w_stream ? 1'b0 : r_ans;
                    n_oev  = w_stream && r_any;
                    n_okey = (w_stream && r_any) ? r_pkey : '0;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Rotation moves the whole chain by one, so FIX turns it on to a full circle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt_a <= '0; r_cnt_b <= '0; r_ovalid <= 1'b0;
            r_pend <= 1'b0; r_i <= '0; r_j <= '0;
        end else begin
            r_state <= n_state; r_cnt_a <= n_cnt_a; r_cnt_b <= n_cnt_b;
            r_ovalid <= n_ovalid; r_pend <= n_pend; r_i <= n_i; r_j <= n_j;
        end
        if (w_acc) begin
            r_op <= w_in_op; r_sel <= w_in_sel;
        end
        r_any <= n_any; r_ans <= n_ans; r_ostat <= n_ostat; r_oans <= n_oans;
        r_okey <= n_okey; r_oev <= n_oev; r_olast <= n_olast; r_pkey <= n_pkey;
    end

    wire [EW-1:0] w_oelem = r_oev ? (r_okey ^ SIGN) : '0;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {4'b0, r_oev, 32'(signed'(w_oelem)), r_oans, r_ostat};
endmodule
`default_nettype wire

>>> rtl/ssp_checker.sv
// Port checker for the sorted set pair engine, bound to the top level.
`default_nettype none
module ssp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    // A stalled result transfer holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // An invalid element carries zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[35] |-> m_axis_tdata[34:3] == 32'd0)
        else $error("invalid element nonzero");
    // A streamed element has status ok and no answer.
    a_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[35] |-> m_axis_tdata[2:0] == 3'd0)
        else $error("element with status");
    // A non-final item is always a streamed element.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[35])
        else $error("non-final item without element");
    // A command is never taken while a result transfer is stalled.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("command taken while result stalled");
endmodule

bind sorted_set_pair_engine ssp_checker u_ssp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
